/* rtl/bass_pkg.sv */
// Shared types and constants for the battery-aware sleep sequencer.
`default_nettype none

package bass_pkg;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        REG_SCREEN_TIMEOUT = 2'd0,
        REG_WIFI_OFF_DELAY = 2'd1,
        REG_BLE_SLOW_DELAY = 2'd2,
        REG_TOUCH_AVAIL    = 2'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_ACTIVITY  = 2'd1,
        REQ_TOUCH     = 2'd2,
        REQ_FORCE_OFF = 2'd3
    } t_req_type;

    localparam logic [1:0] STAGE_AWAKE    = 2'd0;
    localparam logic [1:0] STAGE_WIFI_OFF = 2'd1;
    localparam logic [1:0] STAGE_BLE_SLOW = 2'd2;

    localparam logic [1:0] BLE_NONE  = 2'd0;
    localparam logic [1:0] BLE_AWAKE = 2'd1;
    localparam logic [1:0] BLE_SLEEP = 2'd2;

    localparam logic [1:0] BAT_LOW = 2'd1;

    localparam logic [1:0] SEQ_SLEEP = 2'b01;
    localparam logic [1:0] SEQ_WAKE  = 2'b10;

    localparam logic [31:0] RST_SCREEN_TIMEOUT = 32'd30000;
    localparam logic [31:0] RST_WIFI_OFF_DELAY = 32'd120000;
    localparam logic [31:0] RST_BLE_SLOW_DELAY = 32'd180000;

    localparam logic [31:0] LOW_SCREEN_TIMEOUT = 32'd15000;
    localparam logic [31:0] LOW_WIFI_OFF_DELAY = 32'd30000;
    localparam logic [31:0] LOW_BLE_SLOW_DELAY = 32'd20000;
    localparam logic [31:0] CRIT_SCREEN_TIMEOUT = 32'd3000;
    localparam logic [31:0] WAKE_GUARD_MS = 32'd250;

    typedef struct packed {
        logic [31:0] scr_timeout;
        logic [31:0] wifi_delay;
        logic [31:0] ble_delay;
        logic        touch_available;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic [1:0]  battery_state;
        logic        low_power_latched;
        logic        wifi_enabled;
        logic        wifi_ssid_set;
        logic        ble_enabled;
    } t_in_item;

    typedef struct packed {
        logic        screen_on;
        logic        perf_awake;
        logic [1:0]  radio_stage;
        logic [1:0]  screen_seq;
        logic        wifi_halt;
        logic        wifi_start;
        logic        wifi_forced_off;
        logic [1:0]  ble_request;
        logic        tile_enabled;
        logic        tile_force_off;
        logic [31:0] ignore_until_ms;
        logic        require_release;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/bass_regs.sv */
// Configuration register file behind the APB-style port.
`default_nettype none

module bass_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bass_pkg::APB_AW-1:0] paddr,
    input  wire logic [bass_pkg::APB_DW-1:0] pwdata,
    output logic      [bass_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    output bass_pkg::t_cfg                   o_cfg
);
    import bass_pkg::*;

    t_cfg       r_cfg;
    t_reg_index w_index;
    logic       w_write;

    assign w_index = t_reg_index'(paddr[APB_AW-1:2]);
    assign w_write = psel & penable & pwrite & pready;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scr_timeout     <= RST_SCREEN_TIMEOUT;
            r_cfg.wifi_delay      <= RST_WIFI_OFF_DELAY;
            r_cfg.ble_delay       <= RST_BLE_SLOW_DELAY;
            r_cfg.touch_available <= 1'b1;
        end else if (w_write) begin
            unique case (w_index)
                REG_SCREEN_TIMEOUT: r_cfg.scr_timeout     <= pwdata;
                REG_WIFI_OFF_DELAY: r_cfg.wifi_delay      <= pwdata;
                REG_BLE_SLOW_DELAY: r_cfg.ble_delay       <= pwdata;
                REG_TOUCH_AVAIL:    r_cfg.touch_available <= pwdata[0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_SCREEN_TIMEOUT: prdata = r_cfg.scr_timeout;
            REG_WIFI_OFF_DELAY: prdata = r_cfg.wifi_delay;
            REG_BLE_SLOW_DELAY: prdata = r_cfg.ble_delay;
            REG_TOUCH_AVAIL:    prdata = {{(APB_DW-1){1'b0}}, r_cfg.touch_available};
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/bass_core.sv */
// Sequencer state and the single-pass step logic for one item.
`default_nettype none

module bass_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire bass_pkg::t_in_item i_item,
    input  wire bass_pkg::t_cfg    i_cfg,
    output bass_pkg::t_out_item    o_result
);
    import bass_pkg::*;

    typedef struct packed {
        logic [31:0] last_activity;
        logic [31:0] wake_guard_until;
        logic        screen_awake;
        logic        off_by_timeout;
        logic        perf_awake;
        logic [1:0]  stage;
        logic        wifi_held_off;
        logic        touch_pending;
        logic        tile_enabled;
        logic        tile_force_off;
    } t_state;

    typedef struct packed {
        t_state     s;
        logic [1:0] seq;
        logic [1:0] ble_req;
        logic       wifi_halt;
        logic       wifi_start;
        logic       release_req;
    } t_work;

    t_state r_state;
    t_work  w;

    logic [31:0] idle, to, wd, bd;
    logic        low, crit, allow, crit_blank, should_off, had;
    logic [1:0]  want;

    function automatic t_work f_sleep(input t_work a);
        t_work b;
        b = a;
        if (b.s.screen_awake) begin
            b.s.screen_awake = 1'b0;
            b.seq = b.seq | SEQ_SLEEP;
        end
        return b;
    endfunction

    function automatic t_work f_wake(input t_work a);
        t_work b;
        b = a;
        if (!b.s.screen_awake) begin
            b.s.screen_awake = 1'b1;
            b.seq = b.seq | SEQ_WAKE;
        end
        return b;
    endfunction

    function automatic t_work f_perf(input t_work a, input logic awake);
        t_work b;
        b = a;
        if (b.s.perf_awake != awake) begin
            b.s.perf_awake = awake;
            b.ble_req = awake ? BLE_AWAKE : BLE_SLEEP;
        end
        return b;
    endfunction

    function automatic t_work f_stage(input t_work a, input logic [1:0] st,
                                      input logic ok, input t_in_item it);
        t_work b;
        b = a;
        if (b.s.stage != st) begin
            b.s.stage = st;
            if (st == STAGE_AWAKE) begin
                if (b.s.screen_awake) begin
                    if (b.s.wifi_held_off && ok) begin
                        b.s.wifi_held_off = 1'b0;
                        if (it.wifi_enabled && it.wifi_ssid_set) begin
                            b.wifi_start = 1'b1;
                        end
                    end
                    b.ble_req = BLE_AWAKE;
                end else begin
                    b.ble_req = BLE_SLEEP;
                end
            end else if (st == STAGE_WIFI_OFF) begin
                if (it.wifi_enabled) begin
                    b.s.wifi_held_off = 1'b1;
                    b.wifi_halt = 1'b1;
                end
            end else if (it.ble_enabled) begin
                b.ble_req = BLE_SLEEP;
            end
        end
        return b;
    endfunction

    always_comb begin
        w = '0;
        w.s = r_state;
        idle = i_item.now_ms - r_state.last_activity;
        low = (i_item.battery_state == BAT_LOW);
        crit = i_item.battery_state[1] | i_item.low_power_latched;
        allow = ~crit;
        to = i_cfg.scr_timeout;
        wd = i_cfg.wifi_delay;
        bd = i_cfg.ble_delay;
        crit_blank = 1'b0;
        should_off = 1'b0;
        had = 1'b0;
        want = STAGE_AWAKE;

        case (t_req_type'(i_item.req_type)) inside
            REQ_TICK, REQ_TOUCH: begin
                if (i_item.req_type == REQ_TOUCH) begin
                    w.s.touch_pending = 1'b1;
                end
                if (low) begin
                    if (to == 32'd0 || to > LOW_SCREEN_TIMEOUT) to = LOW_SCREEN_TIMEOUT;
                    if (wd > LOW_WIFI_OFF_DELAY) wd = LOW_WIFI_OFF_DELAY;
                    if (bd > LOW_BLE_SLOW_DELAY) bd = LOW_BLE_SLOW_DELAY;
                end
                if (crit) begin
                    crit_blank = (idle >= CRIT_SCREEN_TIMEOUT);
                    to = CRIT_SCREEN_TIMEOUT;
                    wd = 32'd0;
                    bd = 32'd0;
                end
                w.s.tile_enabled   = ~(low | crit);
                w.s.tile_force_off = low | crit;

                should_off = (to != 32'd0 && idle >= to) || crit_blank;
                if (should_off) begin
                    w.s.off_by_timeout = 1'b1;
                    w = f_sleep(w);
                end else if (!w.s.off_by_timeout) begin
                    w = f_wake(w);
                end
                w = f_perf(w, w.s.screen_awake);

                if (crit || wd == 32'd0 || idle >= wd) begin
                    want = STAGE_WIFI_OFF;
                end else if (bd != 32'd0 && idle >= bd) begin
                    want = STAGE_BLE_SLOW;
                end else begin
                    want = STAGE_AWAKE;
                end
                w = f_stage(w, want, allow, i_item);

                if (i_cfg.touch_available) begin
                    had = w.s.touch_pending;
                    if (had) begin
                        w.s.touch_pending = 1'b0;
                        w.s.last_activity = i_item.now_ms;
                    end
                    if (!w.s.screen_awake && had) begin
                        w.s.off_by_timeout = 1'b0;
                        w = f_wake(w);
                        w = f_perf(w, 1'b1);
                        w = f_stage(w, STAGE_AWAKE, allow, i_item);
                        w.s.wake_guard_until = i_item.now_ms + WAKE_GUARD_MS;
                        w.release_req = 1'b1;
                    end
                end
            end
            REQ_ACTIVITY: begin
                w.s.last_activity = i_item.now_ms;
                w.s.off_by_timeout = 1'b0;
                w = f_wake(w);
                w = f_perf(w, 1'b1);
                if (!crit) begin
                    w = f_stage(w, STAGE_AWAKE, 1'b1, i_item);
                end else begin
                    w = f_stage(w, STAGE_WIFI_OFF, 1'b0, i_item);
                    w.ble_req = BLE_SLEEP;
                end
                w.s.wake_guard_until = i_item.now_ms + WAKE_GUARD_MS;
                w.release_req = 1'b1;
            end
            default: begin
                w = f_sleep(w);
                w = f_perf(w, 1'b0);
            end
        endcase
    end

    always_comb begin
        o_result.screen_on       = w.s.screen_awake;
        o_result.perf_awake      = w.s.perf_awake;
        o_result.radio_stage     = w.s.stage;
        o_result.screen_seq      = w.seq;
        o_result.wifi_halt       = w.wifi_halt;
        o_result.wifi_start      = w.wifi_start;
        o_result.wifi_forced_off = w.s.wifi_held_off;
        o_result.ble_request     = w.ble_req;
        o_result.tile_enabled    = w.s.tile_enabled;
        o_result.tile_force_off  = w.s.tile_force_off;
        o_result.ignore_until_ms = w.s.wake_guard_until;
        o_result.require_release = w.release_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_activity    <= '0;
            r_state.wake_guard_until <= '0;
            r_state.screen_awake     <= 1'b1;
            r_state.off_by_timeout   <= 1'b0;
            r_state.perf_awake       <= 1'b1;
            r_state.stage            <= STAGE_AWAKE;
            r_state.wifi_held_off    <= 1'b0;
            r_state.touch_pending    <= 1'b0;
            r_state.tile_enabled     <= 1'b1;
            r_state.tile_force_off   <= 1'b0;
        end else if (i_step) begin
            r_state <= w.s;
        end
    end

endmodule

`default_nettype wire

/* rtl/battery_aware_sleep_sequencer.sv */
// Top level: input register, step logic, result register and configuration port.
// An accepted item passes through the input register, then the result register.
// Throughput is one item per cycle while the output accepts results; the single
// state update per item sets it. A result waiting at the output holds the item in
// the input register, and the input stalls once that register is full.
// Reset (synchronous, active low) sets state and valid flags, not item data.
`default_nettype none

module battery_aware_sleep_sequencer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire bass_pkg::t_in_item          i_in_item,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output bass_pkg::t_out_item              o_out_item,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bass_pkg::APB_AW-1:0] paddr,
    input  wire logic [bass_pkg::APB_DW-1:0] pwdata,
    output logic      [bass_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);
    import bass_pkg::*;

    t_cfg      w_cfg;
    t_in_item  r_in_item;
    logic      r_in_valid;
    t_out_item w_result;
    t_out_item r_out_item;
    logic      r_out_valid;
    logic      w_advance;

    assign w_advance   = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready  = i_rst_n & (~r_in_valid | w_advance);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    bass_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bass_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

`ifndef SYNTHESIS
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("A stepped item did not produce a result.");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_item))
        else $error("A waiting item was lost from the input register.");

    a_perf_follows_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_item.perf_awake == r_out_item.screen_on)
        else $error("Performance level does not follow the screen state.");

    a_wake_means_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_item.screen_seq[1] || r_out_item.require_release)
            |-> r_out_item.screen_on)
        else $error("A wake was reported but the screen is off.");
`endif

endmodule

`default_nettype wire

/* bench/tb_battery_aware_sleep_sequencer.sv */
// Self-checking testbench for the battery-aware sleep sequencer with a built-in policy predictor.
`timescale 1ns / 100ps

module tb_battery_aware_sleep_sequencer;
    import bass_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic ev_valid = 1'b0;
    logic ev_ready;
    t_in_item ev_item = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    t_out_item res_item;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    t_in_item events_to_send[$];
    t_out_item power_results_due[$];

    logic src_idle_on = 1'b1;
    logic sink_idle_on = 1'b1;
    logic long_stall = 1'b0;
    int gap_left = 0;
    int sink_stall_left = 0;
    int sink_pick;
    int mismatch_count = 0;
    int results_checked = 0;

    logic [31:0] clock_ms = '0;
    logic [1:0] bat_mood = '0;
    logic latched_mood = 1'b0;

    logic [31:0] cfg_screen_to, cfg_wifi_delay, cfg_ble_delay;
    logic cfg_touch_ok;
    logic [31:0] mdl_last_act, mdl_guard;
    logic mdl_screen, mdl_off_by_to, mdl_perf, mdl_wifi_held;
    logic mdl_touch_pend, mdl_tile_en, mdl_tile_off;
    logic [1:0] mdl_stage;
    t_out_item step_res;

    battery_aware_sleep_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (ev_valid),
        .o_in_ready  (ev_ready),
        .i_in_item   (ev_item),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_item  (res_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #6 i_clk = ~i_clk;

    function automatic void reset_policy_state();
        cfg_screen_to = RST_SCREEN_TIMEOUT;
        cfg_wifi_delay = RST_WIFI_OFF_DELAY;
        cfg_ble_delay = RST_BLE_SLOW_DELAY;
        cfg_touch_ok = 1'b1;
        mdl_last_act = '0;
        mdl_guard = '0;
        mdl_screen = 1'b1;
        mdl_off_by_to = 1'b0;
        mdl_perf = 1'b1;
        mdl_wifi_held = 1'b0;
        mdl_touch_pend = 1'b0;
        mdl_tile_en = 1'b1;
        mdl_tile_off = 1'b0;
        mdl_stage = STAGE_AWAKE;
    endfunction

    function automatic void sleep_screen();
        if (!mdl_screen) return;
        mdl_screen = 1'b0;
        step_res.screen_seq |= SEQ_SLEEP;
    endfunction

    function automatic void wake_screen();
        if (mdl_screen) return;
        mdl_screen = 1'b1;
        step_res.screen_seq |= SEQ_WAKE;
    endfunction

    function automatic void set_perf_level(logic lvl);
        if (mdl_perf == lvl) return;
        mdl_perf = lvl;
        step_res.ble_request = lvl ? BLE_AWAKE : BLE_SLEEP;
    endfunction

    function automatic void enter_stage(logic [1:0] st, logic allow, t_in_item ev);
        if (mdl_stage == st) return;
        mdl_stage = st;
        if (st == STAGE_AWAKE) begin
            if (mdl_screen) begin
                if (mdl_wifi_held && allow) begin
                    mdl_wifi_held = 1'b0;
                    if (ev.wifi_enabled && ev.wifi_ssid_set) step_res.wifi_start = 1'b1;
                end
                step_res.ble_request = BLE_AWAKE;
            end else begin
                step_res.ble_request = BLE_SLEEP;
            end
        end else if (st == STAGE_WIFI_OFF) begin
            if (ev.wifi_enabled) begin
                mdl_wifi_held = 1'b1;
                step_res.wifi_halt = 1'b1;
            end
        end else if (ev.ble_enabled) begin
            step_res.ble_request = BLE_SLEEP;
        end
    endfunction

    function automatic void run_policy_tick(t_in_item ev);
        logic [31:0] idle, scr_to, wifi_dl, ble_dl;
        logic low, crit, crit_blank, allow, go_off, had_touch;
        logic [1:0] want;
        idle = ev.now_ms - mdl_last_act;
        scr_to = cfg_screen_to;
        wifi_dl = cfg_wifi_delay;
        ble_dl = cfg_ble_delay;
        low = (ev.battery_state == BAT_LOW);
        crit = ev.battery_state[1] || ev.low_power_latched;
        crit_blank = 1'b0;
        if (low) begin
            if (scr_to == 0 || scr_to > LOW_SCREEN_TIMEOUT) scr_to = LOW_SCREEN_TIMEOUT;
            if (wifi_dl > LOW_WIFI_OFF_DELAY) wifi_dl = LOW_WIFI_OFF_DELAY;
            if (ble_dl > LOW_BLE_SLOW_DELAY) ble_dl = LOW_BLE_SLOW_DELAY;
        end
        if (crit) begin
            crit_blank = (idle >= CRIT_SCREEN_TIMEOUT);
            scr_to = CRIT_SCREEN_TIMEOUT;
            wifi_dl = '0;
            ble_dl = '0;
        end
        mdl_tile_en = !(low || crit);
        mdl_tile_off = low || crit;
        allow = !crit;
        go_off = (scr_to != 0 && idle >= scr_to) || crit_blank;
        if (go_off) begin
            mdl_off_by_to = 1'b1;
            sleep_screen();
        end else if (!mdl_off_by_to) begin
            wake_screen();
        end
        set_perf_level(mdl_screen);
        if (crit || wifi_dl == 0 || idle >= wifi_dl) want = STAGE_WIFI_OFF;
        else if (ble_dl != 0 && idle >= ble_dl) want = STAGE_BLE_SLOW;
        else want = STAGE_AWAKE;
        enter_stage(want, allow, ev);
        if (cfg_touch_ok) begin
            had_touch = mdl_touch_pend;
            if (had_touch) begin
                mdl_touch_pend = 1'b0;
                mdl_last_act = ev.now_ms;
            end
            if (!mdl_screen && had_touch) begin
                mdl_off_by_to = 1'b0;
                wake_screen();
                set_perf_level(1'b1);
                enter_stage(STAGE_AWAKE, allow, ev);
                mdl_guard = ev.now_ms + WAKE_GUARD_MS;
                step_res.require_release = 1'b1;
            end
        end
    endfunction

    function automatic t_out_item advance_power_policy(t_in_item ev);
        logic crit;
        step_res = '0;
        crit = ev.battery_state[1] || ev.low_power_latched;
        case (ev.req_type)
            REQ_TICK: begin
                run_policy_tick(ev);
            end
            REQ_TOUCH: begin
                mdl_touch_pend = 1'b1;
                run_policy_tick(ev);
            end
            REQ_ACTIVITY: begin
                mdl_last_act = ev.now_ms;
                mdl_off_by_to = 1'b0;
                wake_screen();
                set_perf_level(1'b1);
                if (!crit) begin
                    enter_stage(STAGE_AWAKE, 1'b1, ev);
                end else begin
                    enter_stage(STAGE_WIFI_OFF, 1'b0, ev);
                    step_res.ble_request = BLE_SLEEP;
                end
                mdl_guard = ev.now_ms + WAKE_GUARD_MS;
                step_res.require_release = 1'b1;
            end
            default: begin
                sleep_screen();
                set_perf_level(1'b0);
            end
        endcase
        step_res.screen_on = mdl_screen;
        step_res.perf_awake = mdl_perf;
        step_res.radio_stage = mdl_stage;
        step_res.wifi_forced_off = mdl_wifi_held;
        step_res.tile_enabled = mdl_tile_en;
        step_res.tile_force_off = mdl_tile_off;
        step_res.ignore_until_ms = mdl_guard;
        return step_res;
    endfunction

    function automatic void push_event(t_req_type kind, logic [31:0] at_ms, logic [1:0] bat,
                                       logic latched, logic [2:0] radios);
        t_in_item ev;
        ev.req_type = kind;
        ev.now_ms = at_ms;
        ev.battery_state = bat;
        ev.low_power_latched = latched;
        ev.wifi_enabled = radios[2];
        ev.wifi_ssid_set = radios[1];
        ev.ble_enabled = radios[0];
        events_to_send.push_back(ev);
    endfunction

    function automatic void push_random_events(int count);
        int pick;
        t_req_type kind;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) clock_ms = $urandom;
            else if (pick < 10) clock_ms += $urandom_range(40000, 250000);
            else if (pick < 30) clock_ms += $urandom_range(3000, 40000);
            else clock_ms += $urandom_range(0, 3000);
            if ($urandom_range(0, 19) == 0) begin
                pick = $urandom_range(0, 9);
                bat_mood = (pick < 6) ? 2'd0 : (pick < 8) ? BAT_LOW : 2'(pick - 6);
                latched_mood = ($urandom_range(0, 9) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) kind = REQ_TICK;
            else if (pick < 65) kind = REQ_ACTIVITY;
            else if (pick < 88) kind = REQ_TOUCH;
            else kind = REQ_FORCE_OFF;
            push_event(kind, clock_ms, bat_mood, latched_mood,
                       {$urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                        $urandom_range(0, 3) != 0});
        end
    endfunction

    function automatic int pick_gap();
        int pick;
        if (!src_idle_on) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic compare_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result %0d: %s expected %0h, got %0h",
                         results_checked, fname, want, got);
        end
    endtask

    task automatic check_result(t_out_item got);
        t_out_item exp;
        results_checked++;
        if (power_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result %0d arrived with nothing expected: %h", results_checked, got);
            return;
        end
        exp = power_results_due.pop_front();
        compare_field("screen_on", 32'(exp.screen_on), 32'(got.screen_on));
        compare_field("perf_awake", 32'(exp.perf_awake), 32'(got.perf_awake));
        compare_field("radio_stage", 32'(exp.radio_stage), 32'(got.radio_stage));
        compare_field("screen_seq", 32'(exp.screen_seq), 32'(got.screen_seq));
        compare_field("wifi_halt", 32'(exp.wifi_halt), 32'(got.wifi_halt));
        compare_field("wifi_start", 32'(exp.wifi_start), 32'(got.wifi_start));
        compare_field("wifi_forced_off", 32'(exp.wifi_forced_off), 32'(got.wifi_forced_off));
        compare_field("ble_request", 32'(exp.ble_request), 32'(got.ble_request));
        compare_field("tile_enabled", 32'(exp.tile_enabled), 32'(got.tile_enabled));
        compare_field("tile_force_off", 32'(exp.tile_force_off), 32'(got.tile_force_off));
        compare_field("ignore_until_ms", exp.ignore_until_ms, got.ignore_until_ms);
        compare_field("require_release", 32'(exp.require_release), 32'(got.require_release));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ev_valid <= 1'b0;
        end else begin
            if (ev_valid && ev_ready) begin
                power_results_due.push_back(advance_power_policy(ev_item));
            end
            if (!ev_valid || ev_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    ev_valid <= 1'b0;
                end else if (events_to_send.size() != 0) begin
                    ev_item <= events_to_send.pop_front();
                    ev_valid <= 1'b1;
                    gap_left = pick_gap();
                end else begin
                    ev_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_valid && res_ready) check_result(res_item);
            if (long_stall) begin
                res_ready <= 1'b0;
            end else if (sink_stall_left > 0) begin
                sink_stall_left--;
                res_ready <= 1'b0;
            end else if (!sink_idle_on) begin
                res_ready <= 1'b1;
            end else begin
                sink_pick = $urandom_range(0, 99);
                if (sink_pick < 3) begin
                    sink_stall_left = $urandom_range(8, 40);
                    res_ready <= 1'b0;
                end else begin
                    res_ready <= (sink_pick >= 25);
                end
            end
        end
    end

    task automatic write_register(t_reg_index idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SCREEN_TIMEOUT: cfg_screen_to = value;
            REG_WIFI_OFF_DELAY: cfg_wifi_delay = value;
            REG_BLE_SLOW_DELAY: cfg_ble_delay = value;
            default: cfg_touch_ok = value[0];
        endcase
    endtask

    task automatic apply_settings(logic [31:0] scr, logic [31:0] wifi, logic [31:0] ble,
                                  logic touch);
        write_register(REG_SCREEN_TIMEOUT, scr);
        write_register(REG_WIFI_OFF_DELAY, wifi);
        write_register(REG_BLE_SLOW_DELAY, ble);
        write_register(REG_TOUCH_AVAIL, {31'b0, touch});
    endtask

    task automatic wait_until_idle();
        while (events_to_send.size() != 0 || ev_valid || power_results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        reset_policy_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walks through timeout, touch wake, wifi restore, low and critical battery and wrap.
        push_event(REQ_TICK, 32'd0, 2'd0, 1'b0, 3'b111);
        push_event(REQ_TICK, 32'd31000, 2'd0, 1'b0, 3'b111);
        push_event(REQ_TOUCH, 32'd31100, 2'd0, 1'b0, 3'b111);
        push_event(REQ_TICK, 32'd200000, 2'd0, 1'b0, 3'b111);
        push_event(REQ_ACTIVITY, 32'd200100, 2'd0, 1'b0, 3'b111);
        push_event(REQ_FORCE_OFF, 32'd200200, 2'd0, 1'b0, 3'b111);
        push_event(REQ_TICK, 32'd200300, 2'd0, 1'b0, 3'b111);
        push_event(REQ_TICK, 32'd210000, BAT_LOW, 1'b0, 3'b111);
        push_event(REQ_TICK, 32'd216000, BAT_LOW, 1'b0, 3'b111);
        push_event(REQ_TICK, 32'd221000, BAT_LOW, 1'b0, 3'b111);
        push_event(REQ_TICK, 32'd231000, BAT_LOW, 1'b0, 3'b111);
        push_event(REQ_ACTIVITY, 32'd231100, 2'd2, 1'b0, 3'b111);
        push_event(REQ_TICK, 32'd234200, 2'd3, 1'b0, 3'b111);
        push_event(REQ_TOUCH, 32'd234300, 2'd0, 1'b1, 3'b111);
        push_event(REQ_TICK, 32'd234400, 2'd0, 1'b0, 3'b000);
        push_event(REQ_TICK, 32'hFFFF_FFFF, 2'd0, 1'b0, 3'b101);
        push_event(REQ_ACTIVITY, 32'hFFFF_FFFF, 2'd0, 1'b0, 3'b010);
        push_event(REQ_TICK, 32'd0, 2'd0, 1'b0, 3'b111);
        push_event(REQ_TOUCH, 32'h7FFF_FFFF, BAT_LOW, 1'b0, 3'b000);
        push_event(REQ_FORCE_OFF, 32'h8000_0000, 2'd3, 1'b1, 3'b111);
        push_event(REQ_TOUCH, 32'h8000_0100, 2'd0, 1'b0, 3'b111);
        clock_ms = 32'h8000_0200;
        push_random_events(175);
        wait_until_idle();

        apply_settings(32'd0, 32'd0, 32'd0, 1'b1);
        src_idle_on <= 1'b0;
        clock_ms = 32'hFFFE_0000;
        push_random_events(175);
        wait_until_idle();

        apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        src_idle_on <= 1'b1;
        sink_idle_on <= 1'b0;
        push_random_events(175);
        wait_until_idle();

        apply_settings(32'd5000, 32'd8000, 32'd6000, 1'b1);
        sink_idle_on <= 1'b1;
        push_random_events(175);
        long_stall <= 1'b1;
        repeat (400) @(posedge i_clk);
        long_stall <= 1'b0;
        wait_until_idle();

        apply_settings($urandom_range(0, 60000), $urandom_range(0, 60000),
                       $urandom_range(0, 60000), 1'($urandom_range(0, 1)));
        push_random_events(175);
        wait_until_idle();

        apply_settings(RST_SCREEN_TIMEOUT, RST_WIFI_OFF_DELAY, RST_BLE_SLOW_DELAY, 1'b1);
        src_idle_on <= 1'b0;
        sink_idle_on <= 1'b0;
        push_random_events(175);
        wait_until_idle();

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/bass_pkg.sv
rtl/bass_regs.sv
rtl/bass_core.sv
rtl/battery_aware_sleep_sequencer.sv
bench/tb_battery_aware_sleep_sequencer.sv
